// File: hw/rtl/wwfc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wwfc_pkg
// Shared types and constants of the windowed watchdog fault counter.
// ============================================================================
package wwfc_pkg;

    // Width of the window and activity prescaler counters.
    localparam int COUNT_WIDTH = 16;

    // Width of the configuration registers that hold counter thresholds.
    localparam int THRESH_WIDTH = 16;

    // Common width used when a counter is compared against a threshold.
    localparam int CMP_WIDTH = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;

    localparam int FAULT_WIDTH   = 4;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 16;

    // Reset values of the configuration registers.
    localparam logic [THRESH_WIDTH-1:0] WINDOW_MIN_RST      = THRESH_WIDTH'(34800);
    localparam logic [THRESH_WIDTH-1:0] WINDOW_MAX_RST      = THRESH_WIDTH'(37800);
    localparam logic [FAULT_WIDTH-1:0]  FAULT_LIMIT_RST     = FAULT_WIDTH'(10);
    localparam logic [THRESH_WIDTH-1:0] ACTIVITY_PERIOD_RST = THRESH_WIDTH'(3600);

    localparam logic [FAULT_WIDTH-1:0] FAULT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_KICK  = 2'd2,
        ACT_STOP  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_RUNNING  = 2'd1,
        MODE_DISABLED = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_WINDOW_MIN      = 2'd0,
        CFG_WINDOW_MAX      = 2'd1,
        CFG_FAULT_LIMIT     = 2'd2,
        CFG_ACTIVITY_PERIOD = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        action_t action;
        logic    with_watchdog;
    } evt_t;

    typedef struct packed {
        mode_t                  system_state;
        logic                   shutdown_pulse;
        logic                   detect_enable;
        logic                   activity_pulse;
        logic [FAULT_WIDTH-1:0] fault_count;
    } res_t;

endpackage

// File: hw/rtl/windowed_watchdog_fault_counter_top.sv
`timescale 1ns / 1ps
// ============================================================================
// windowed_watchdog_fault_counter_top
// Windowed watchdog with a leaky fault counter and an activity prescaler.
// ============================================================================
//
// Usage:
// Each request on the event channel (evt_valid, evt_stall, evt_data) carries
// one event: tick, start, kick or stop. Every event produces exactly one
// request on the result channel (res_valid, res_stall, res_data) with the
// system state, the shutdown pulse, the detection enable, the activity pulse
// and the fault count after that event.
// An accepted event's result is registered, into the result register or,
// while a stalled result waits there, into the skid register. While evt_stall
// is low one event can be accepted in every cycle; the whole update is a
// compare, an increment and selection, so the sustained rate is one per cycle.
// A two-entry output stage (result register plus skid register) keeps the
// event side running while a result waits. When the receiver stalls, the
// next event still goes into the skid register; only once both entries are
// full is evt_stall raised, and it is driven straight from a register.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user writes them only while idle, which the block does not enforce.
// Reset (rst_n low, asynchronous) restores the default thresholds, disarms
// the watchdog, clears all counters, selects idle and empties the outputs.
//
module windowed_watchdog_fault_counter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                evt_valid,
    output logic                                evt_stall,
    input  wwfc_pkg::evt_t                      evt_data,
    output logic                                res_valid,
    input  logic                                res_stall,
    output wwfc_pkg::res_t                      res_data,
    input  logic                                cfg_we,
    input  logic [wwfc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [wwfc_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
    import wwfc_pkg::*;

    // Configuration registers.
    logic [THRESH_WIDTH-1:0] window_min_reg;
    logic [THRESH_WIDTH-1:0] window_max_reg;
    logic [FAULT_WIDTH-1:0]  fault_limit_reg;
    logic [THRESH_WIDTH-1:0] activity_period_reg;

    // Watchdog state.
    logic                   armed_reg, armed_next;
    logic [COUNT_WIDTH-1:0] window_count_reg, window_count_next;
    logic [FAULT_WIDTH-1:0] faults_reg, faults_next;
    mode_t                  mode_reg, mode_next;
    logic                   detect_on_reg, detect_on_next;
    logic [COUNT_WIDTH-1:0] prescale_count_reg, prescale_count_next;

    // Output stage.
    logic res_valid_reg;
    res_t res_data_reg;
    logic skid_valid_reg;
    res_t skid_data_reg;

    logic accept;
    logic res_leave;
    res_t result;

    logic [COUNT_WIDTH-1:0] window_inc;
    logic [COUNT_WIDTH-1:0] prescale_inc;
    logic                   late;
    logic                   early;
    logic                   over_limit;
    logic                   shut;
    logic                   act;

    assign accept    = evt_valid && !skid_valid_reg;
    assign res_leave = res_valid_reg && !res_stall;

    assign window_inc   = window_count_reg + COUNT_WIDTH'(1);
    assign prescale_inc = prescale_count_reg + COUNT_WIDTH'(1);
    assign late         = CMP_WIDTH'(window_inc) > CMP_WIDTH'(window_max_reg);
    assign early        = CMP_WIDTH'(window_count_reg) < CMP_WIDTH'(window_min_reg);
    assign over_limit   = faults_reg > fault_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_min_reg      <= WINDOW_MIN_RST;
            window_max_reg      <= WINDOW_MAX_RST;
            fault_limit_reg     <= FAULT_LIMIT_RST;
            activity_period_reg <= ACTIVITY_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_WINDOW_MIN:      window_min_reg      <= cfg_data[THRESH_WIDTH-1:0];
                CFG_WINDOW_MAX:      window_max_reg      <= cfg_data[THRESH_WIDTH-1:0];
                CFG_FAULT_LIMIT:     fault_limit_reg     <= cfg_data[FAULT_WIDTH-1:0];
                CFG_ACTIVITY_PERIOD: activity_period_reg <= cfg_data[THRESH_WIDTH-1:0];
                default:             window_min_reg      <= window_min_reg;
            endcase
        end
    end

    // Event decode. A fault either counts up and restarts the window, or,
    // once the count is above the limit, disables the system; a disabling
    // fault neither restarts the window nor changes the arming, so later
    // faults disable again.
    always_comb
    begin
        armed_next          = armed_reg;
        window_count_next   = window_count_reg;
        faults_next         = faults_reg;
        mode_next           = mode_reg;
        detect_on_next      = detect_on_reg;
        prescale_count_next = prescale_count_reg;
        shut                = 1'b0;
        act                 = 1'b0;

        unique case (evt_data.action)
            ACT_TICK:
            begin
                if (armed_reg)
                begin
                    window_count_next = window_inc;
                    if (late)
                    begin
                        if (over_limit)
                        begin
                            mode_next      = MODE_DISABLED;
                            detect_on_next = 1'b0;
                            shut           = 1'b1;
                        end
                        else
                        begin
                            if (faults_reg != FAULT_MAX)
                                faults_next = faults_reg + FAULT_WIDTH'(1);
                            window_count_next = '0;
                        end
                    end
                end
                // A period at or below the new count wraps the prescaler,
                // which also covers a period of zero and a lowered period.
                if (CMP_WIDTH'(prescale_inc) >= CMP_WIDTH'(activity_period_reg))
                begin
                    prescale_count_next = '0;
                    act                 = 1'b1;
                end
                else
                    prescale_count_next = prescale_inc;
            end
            ACT_START:
            begin
                if (evt_data.with_watchdog)
                    armed_next = 1'b1;
                window_count_next = '0;
                faults_next       = '0;
                mode_next         = MODE_RUNNING;
                detect_on_next    = 1'b1;
            end
            ACT_KICK:
            begin
                if (armed_reg)
                begin
                    if (early)
                    begin
                        if (over_limit)
                        begin
                            mode_next      = MODE_DISABLED;
                            detect_on_next = 1'b0;
                            shut           = 1'b1;
                        end
                        else
                        begin
                            if (faults_reg != FAULT_MAX)
                                faults_next = faults_reg + FAULT_WIDTH'(1);
                            window_count_next = '0;
                        end
                    end
                    else
                    begin
                        // A kick inside the window forgives one fault.
                        if (faults_reg != '0)
                            faults_next = faults_reg - FAULT_WIDTH'(1);
                        window_count_next = '0;
                    end
                end
            end
            ACT_STOP:
            begin
                armed_next        = 1'b0;
                window_count_next = '0;
                faults_next       = '0;
                mode_next         = MODE_IDLE;
                detect_on_next    = 1'b0;
            end
            default:
            begin
                armed_next = armed_reg;
            end
        endcase

        result.system_state   = mode_next;
        result.shutdown_pulse = shut;
        result.detect_enable  = detect_on_next;
        result.activity_pulse = act;
        result.fault_count    = faults_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg          <= 1'b0;
            window_count_reg   <= '0;
            faults_reg         <= '0;
            mode_reg           <= MODE_IDLE;
            detect_on_reg      <= 1'b0;
            prescale_count_reg <= '0;
        end
        else if (accept)
        begin
            armed_reg          <= armed_next;
            window_count_reg   <= window_count_next;
            faults_reg         <= faults_next;
            mode_reg           <= mode_next;
            detect_on_reg      <= detect_on_next;
            prescale_count_reg <= prescale_count_next;
        end
    end

    // Output stage: a new result goes to the result register when it is
    // free or draining, otherwise into the skid register. The skid entry
    // moves up as soon as the result register drains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (res_valid_reg && !res_leave)
                skid_valid_reg <= 1'b1;
            else
                res_valid_reg <= 1'b1;
        end
        else if (res_leave)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (res_valid_reg && !res_leave)
                skid_data_reg <= result;
            else
                res_data_reg <= result;
        end
        else if (res_leave && skid_valid_reg)
            res_data_reg <= skid_data_reg;
    end

    assign evt_stall = skid_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

// File: hw/rtl/wwfc_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// wwfc_checker
// Port-level checks of the windowed watchdog fault counter.
// ============================================================================
module wwfc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                evt_valid,
    input logic                                evt_stall,
    input wwfc_pkg::evt_t                      evt_data,
    input logic                                res_valid,
    input logic                                res_stall,
    input wwfc_pkg::res_t                      res_data,
    input logic                                cfg_we,
    input logic [wwfc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input logic [wwfc_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
    import wwfc_pkg::*;

    // The event side only stalls when both output entries hold results.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        evt_stall |-> res_valid)
        else $error("event side stalled with no result pending");

    // A shutdown always leaves the system disabled with detection off.
    a_shutdown_disables: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.shutdown_pulse) |->
            (res_data.system_state == MODE_DISABLED && !res_data.detect_enable))
        else $error("shutdown reported without disabling");

    // In idle the watchdog is disarmed and its fault count is clear.
    a_idle_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.system_state == MODE_IDLE) |->
            (!res_data.detect_enable && res_data.fault_count == '0
             && !res_data.shutdown_pulse))
        else $error("idle result shows detection, faults or shutdown");

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> res_valid)
        else $error("result dropped while stalled");

endmodule

bind windowed_watchdog_fault_counter_top wwfc_checker u_wwfc_checker (.*);

// File: sim/tb_windowed_watchdog_fault_counter_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_windowed_watchdog_fault_counter_top
// Self-checking bench for the windowed watchdog fault counter. A queue-fed
// driver sends tick, start, kick and stop requests in random bursts, while a
// monitor stalls the result side on its own pattern. Every result is checked
// field by field against a behavioral copy of the watchdog. The thresholds
// are reprogrammed between phases. Phases cover the reset thresholds, short
// windows with repeated disables, fault count saturation, and random
// thresholds with well-formed kick sequences.
// ============================================================================
module tb_windowed_watchdog_fault_counter_top;

    import wwfc_pkg::*;

    // Cycles without any accepted request on either channel before the run
    // is declared hung. The slowest legal stretch is a receiver stall streak
    // or a sender gap, both far shorter than this.
    localparam int IDLE_LIMIT = 2000;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      evt_valid = 1'b0;
    logic                      evt_stall;
    evt_t                      evt_data  = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    res_t                      res_data;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    windowed_watchdog_fault_counter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_data  (evt_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Behavioral copy of the watchdog: thresholds and state.
    // ------------------------------------------------------------------------
    logic [THRESH_WIDTH-1:0] win_min_thr = WINDOW_MIN_RST;
    logic [THRESH_WIDTH-1:0] win_max_thr = WINDOW_MAX_RST;
    logic [FAULT_WIDTH-1:0]  limit_thr   = FAULT_LIMIT_RST;
    logic [THRESH_WIDTH-1:0] period_thr  = ACTIVITY_PERIOD_RST;

    logic                   wd_armed  = 1'b0;
    logic [COUNT_WIDTH-1:0] wd_window = '0;
    logic [FAULT_WIDTH-1:0] wd_faults = '0;
    mode_t                  wd_mode   = MODE_IDLE;
    logic                   wd_detect = 1'b0;
    logic [COUNT_WIDTH-1:0] pre_count = '0;

    evt_t pending_events[$];
    res_t expected_results[$];

    int events_queued = 0;
    int results_seen  = 0;
    int error_count   = 0;
    int idle_cycles   = 0;

    // Sender burst shaping and receiver stall pattern.
    int burst_left;
    int gap_left;
    int stall_mode;
    int stall_age;

    res_t want;

    // A fault either bumps the leaky count and restarts the window, or, once
    // the count is above the limit, disables the system. The disabling path
    // leaves the window and arming alone, so later faults disable again.
    function automatic logic register_fault();
        if (wd_faults > limit_thr) begin
            wd_mode   = MODE_DISABLED;
            wd_detect = 1'b0;
            return 1'b1;
        end
        if (wd_faults != FAULT_MAX)
            wd_faults = wd_faults + 1'b1;
        wd_window = '0;
        return 1'b0;
    endfunction

    // Applies one event to the behavioral copy and returns the result the
    // block must produce for it.
    function automatic res_t advance_watchdog(evt_t ev);
        res_t r;
        logic shut;
        logic act;
        shut = 1'b0;
        act  = 1'b0;
        case (ev.action)
            ACT_TICK: begin
                if (wd_armed) begin
                    wd_window = wd_window + 1'b1;
                    if (wd_window > win_max_thr)
                        shut = register_fault();
                end
                // The prescaler runs whether or not the watchdog is armed.
                pre_count = pre_count + 1'b1;
                if (pre_count >= period_thr) begin
                    pre_count = '0;
                    act       = 1'b1;
                end
            end
            ACT_START: begin
                if (ev.with_watchdog)
                    wd_armed = 1'b1;
                wd_window = '0;
                wd_faults = '0;
                wd_mode   = MODE_RUNNING;
                wd_detect = 1'b1;
            end
            ACT_KICK: begin
                if (wd_armed) begin
                    if (wd_window < win_min_thr) begin
                        shut = register_fault();
                    end
                    else begin
                        if (wd_faults != '0)
                            wd_faults = wd_faults - 1'b1;
                        wd_window = '0;
                    end
                end
            end
            default: begin
                wd_armed  = 1'b0;
                wd_window = '0;
                wd_faults = '0;
                wd_mode   = MODE_IDLE;
                wd_detect = 1'b0;
            end
        endcase
        r.system_state   = wd_mode;
        r.shutdown_pulse = shut;
        r.detect_enable  = wd_detect;
        r.activity_pulse = act;
        r.fault_count    = wd_faults;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Event driver. A request is accepted at an edge where valid is high and
    // stall is low; the prediction is made right there, from the payload
    // that was on the bus. A stalled request keeps its payload untouched.
    // The sender alternates random bursts and gaps; now and then it picks a
    // long burst without gaps so that back-to-back traffic is covered too.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid  <= 1'b0;
            evt_data   <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (evt_valid && !evt_stall)
                expected_results.push_back(advance_watchdog(evt_data));

            if (!evt_valid || !evt_stall)
            begin
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        burst_left = 300;
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(0, 7);
                    end
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    evt_valid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    evt_data  <= pending_events.pop_front();
                    evt_valid <= 1'b1;
                    burst_left--;
                end
                else
                begin
                    evt_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Whenever stall_age runs out, a stall pattern is picked at
    // random among no stall, light and heavy random stall, and a strict toggle.
    // Each accepted result is matched against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_mode = 0;
            stall_age  = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, res_data);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_data.system_state !== want.system_state)
                    begin
                        $display("%0t: system_state expected %0d, actual %0d",
                                 $time, want.system_state, res_data.system_state);
                        error_count++;
                    end
                    if (res_data.shutdown_pulse !== want.shutdown_pulse)
                    begin
                        $display("%0t: shutdown_pulse expected %0d, actual %0d",
                                 $time, want.shutdown_pulse, res_data.shutdown_pulse);
                        error_count++;
                    end
                    if (res_data.detect_enable !== want.detect_enable)
                    begin
                        $display("%0t: detect_enable expected %0d, actual %0d",
                                 $time, want.detect_enable, res_data.detect_enable);
                        error_count++;
                    end
                    if (res_data.activity_pulse !== want.activity_pulse)
                    begin
                        $display("%0t: activity_pulse expected %0d, actual %0d",
                                 $time, want.activity_pulse, res_data.activity_pulse);
                        error_count++;
                    end
                    if (res_data.fault_count !== want.fault_count)
                    begin
                        $display("%0t: fault_count expected %0d, actual %0d",
                                 $time, want.fault_count, res_data.fault_count);
                        error_count++;
                    end
                end
            end

            stall_age++;
            if (stall_age >= 61)
            begin
                stall_age  = 0;
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                2:       res_stall <= ($urandom_range(0, 3) != 0);
                default: res_stall <= ~res_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Hang detection: any accepted request on either side resets the count.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_valid && !evt_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_event(input action_t a, input logic w);
        evt_t ev;
        ev.action        = a;
        ev.with_watchdog = w;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++)
            queue_event(ACT_TICK, 1'($urandom_range(0, 1)));
    endtask

    // Blocks the test sequence until every queued request has produced its
    // result. Every event yields exactly one result, so once the counts
    // agree the block is idle.
    task automatic wait_drained();
        while (results_seen != events_queued)
            @(posedge clk);
    endtask

    // Programs all four thresholds back to back and mirrors them into the
    // behavioral copy. Only called while the block is idle.
    task automatic set_thresholds(input logic [THRESH_WIDTH-1:0] lo,
                                  input logic [THRESH_WIDTH-1:0] hi,
                                  input logic [FAULT_WIDTH-1:0]  lim,
                                  input logic [THRESH_WIDTH-1:0] per);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WINDOW_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_WINDOW_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_FAULT_LIMIT;
        cfg_data  <= CFG_DATA_WIDTH'(lim);
        @(posedge clk);
        cfg_index <= CFG_ACTIVITY_PERIOD;
        cfg_data  <= per;
        @(posedge clk);
        cfg_we    <= 1'b0;
        win_min_thr = lo;
        win_max_thr = hi;
        limit_thr   = lim;
        period_thr  = per;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [THRESH_WIDTH-1:0] lo;
        logic [THRESH_WIDTH-1:0] hi;
        logic [FAULT_WIDTH-1:0]  lim;
        logic [THRESH_WIDTH-1:0] per;
        int                      span;
        int                      pick;
        int                      phase_items;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds: every event with both arming values, an early
        // kick while armed, start while armed without re-arming, and ticks
        // and kicks with the watchdog disarmed.
        queue_event(ACT_START, 1'b0);
        queue_event(ACT_TICK,  1'b1);
        queue_event(ACT_KICK,  1'b0);
        queue_event(ACT_STOP,  1'b1);
        queue_event(ACT_START, 1'b1);
        queue_event(ACT_TICK,  1'b0);
        queue_event(ACT_KICK,  1'b1);
        queue_event(ACT_KICK,  1'b0);
        queue_event(ACT_START, 1'b0);
        queue_event(ACT_KICK,  1'b0);
        queue_event(ACT_STOP,  1'b0);
        queue_event(ACT_TICK,  1'b1);
        wait_drained();

        // Short window with a zero fault limit and a zero activity period:
        // late fault, kick in the window, disable, repeated disable on every
        // later tick, restart from disabled, early kick, disarmed events.
        set_thresholds(16'd2, 16'd4, 4'd0, 16'd0);
        queue_event(ACT_START, 1'b1);
        queue_ticks(5);
        queue_ticks(2);
        queue_event(ACT_KICK, 1'b0);
        queue_ticks(5);
        queue_ticks(6);
        queue_event(ACT_START, 1'b0);
        queue_event(ACT_KICK, 1'b1);
        queue_event(ACT_KICK, 1'b0);
        queue_event(ACT_STOP, 1'b0);
        queue_event(ACT_KICK, 1'b1);
        queue_event(ACT_TICK, 1'b0);
        wait_drained();

        // Limit of fifteen with a zero window: every armed tick faults and
        // the count saturates at fifteen without ever disabling. A zero
        // minimum means no kick is early.
        set_thresholds(16'd0, 16'd0, 4'd15, 16'd1);
        queue_event(ACT_START, 1'b1);
        queue_ticks(18);
        queue_event(ACT_KICK, 1'b0);
        queue_event(ACT_STOP, 1'b1);
        wait_drained();

        // Random phases. Each one programs fresh thresholds, extremes mixed
        // in, and mostly sends runs of ticks closed by a kick so that the
        // window edges, fault build-up and disables are reached often.
        for (int phase = 0; phase < 12; phase++)
        begin
            pick = $urandom_range(0, 7);
            lo   = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0 :
                   THRESH_WIDTH'($urandom_range(0, 10));
            pick = $urandom_range(0, 7);
            hi   = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd0 :
                   THRESH_WIDTH'($urandom_range(0, 16));
            lim  = ($urandom_range(0, 9) == 0) ? 4'd15 :
                   FAULT_WIDTH'($urandom_range(0, 14));
            pick = $urandom_range(0, 7);
            per  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                   THRESH_WIDTH'($urandom_range(1, 40));
            // The first random phase starts with an extreme setting.
            if (phase == 0)
            begin
                lo = 16'hFFFF;
                hi = 16'hFFFF;
            end
            set_thresholds(lo, hi, lim, per);

            span = (hi < 30) ? int'(hi) + 3 : 30;
            phase_items = 0;
            queue_event(ACT_START, 1'b1);
            while (phase_items < 150)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    queue_event(ACT_START, $urandom_range(0, 3) != 0);
                    phase_items++;
                end
                else if (pick < 12)
                begin
                    queue_event(ACT_STOP, 1'($urandom_range(0, 1)));
                    phase_items++;
                end
                else if (pick < 25)
                begin
                    queue_event(action_t'($urandom_range(0, 3)),
                                1'($urandom_range(0, 1)));
                    phase_items++;
                end
                else
                begin
                    pick = $urandom_range(0, span);
                    queue_ticks(pick);
                    queue_event(ACT_KICK, 1'($urandom_range(0, 1)));
                    phase_items += pick + 1;
                end
            end
            wait_drained();
        end

        // All requests are in; give the output stage time to show anything
        // spurious before the verdict.
        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results expected but never delivered",
                     $time, expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
